// ----- sv/mts_pkg.sv -----
// Shared constants, tables, codes and types of the melody tone sequencer.
`default_nettype none
package mts_pkg;

	// Clock and song geometry
	localparam int CLOCK_HZ    = 25000000;
	localparam int SONG_LENGTH = 39;
	localparam int TABLE_SIZE  = 39;

	// Field widths
	localparam int OP_W   = 2;
	localparam int FREQ_W = 15;
	localparam int TICK_W = 8;
	localparam int HP_W   = 24;
	localparam int DAC_W  = 10;
	localparam int POS_W  = 6;
	localparam int NOTE_W = 10;

	// Divider geometry: quotient of (CLOCK_HZ / 2) by the pitch
	localparam int HALF_CLK = CLOCK_HZ / 2;
	localparam int QUO_W    = $clog2(HALF_CLK + 1);
	localparam int CNT_W    = $clog2(QUO_W + 1);
	localparam logic [HP_W-1:0] HP_MAX = '1;

	// Operation codes
	localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OP_W-1:0] OP_EFFECT = 2'd1;
	localparam logic [OP_W-1:0] OP_HALF   = 2'd2;

	// Note pitches in hertz
	localparam logic [NOTE_W-1:0] P_E5  = 10'd659;
	localparam logic [NOTE_W-1:0] P_B4  = 10'd494;
	localparam logic [NOTE_W-1:0] P_C5  = 10'd523;
	localparam logic [NOTE_W-1:0] P_D5  = 10'd587;
	localparam logic [NOTE_W-1:0] P_A4  = 10'd440;
	localparam logic [NOTE_W-1:0] P_F5  = 10'd698;
	localparam logic [NOTE_W-1:0] P_A5  = 10'd880;
	localparam logic [NOTE_W-1:0] P_G5  = 10'd784;
	localparam logic [NOTE_W-1:0] P_SIL = 10'd0;
	localparam int PITCH_E5 = 659;

	// Reset values
	localparam logic [DAC_W-1:0]  DAC_LEVEL_RST = 10'd128;
	localparam logic [HP_W-1:0]   RELOAD_RST    = HP_W'(HALF_CLK / PITCH_E5);
	localparam logic [TICK_W-1:0] PAST_END_LEN  = 8'd20;

	localparam logic [NOTE_W-1:0] TUNE_PITCH [TABLE_SIZE] = '{
		P_E5, P_B4, P_C5, P_D5, P_C5, P_B4, P_A4, P_A4, P_C5, P_E5, P_D5, P_C5,
		P_B4, P_C5, P_D5, P_E5, P_C5, P_A4, P_A4, P_SIL,
		P_D5, P_F5, P_A5, P_G5, P_F5, P_E5, P_C5, P_E5, P_D5, P_C5,
		P_B4, P_B4, P_C5, P_D5, P_E5, P_C5, P_A4, P_A4, P_SIL
	};

	localparam logic [TICK_W-1:0] TUNE_LEN [TABLE_SIZE] = '{
		8'd20, 8'd10, 8'd10, 8'd20, 8'd10, 8'd10, 8'd20, 8'd10, 8'd10, 8'd20, 8'd10, 8'd10,
		8'd20, 8'd10, 8'd20, 8'd20, 8'd20, 8'd20, 8'd20, 8'd20,
		8'd20, 8'd10, 8'd20, 8'd10, 8'd10, 8'd30, 8'd10, 8'd20, 8'd10, 8'd10,
		8'd20, 8'd10, 8'd10, 8'd20, 8'd20, 8'd20, 8'd20, 8'd20, 8'd20
	};

	// Pitch of a song position; positions past the table are silent
	function automatic logic [FREQ_W-1:0] tune_pitch(input logic [POS_W-1:0] pos);
		logic [FREQ_W-1:0] p;
		p = '0;
		if (32'(pos) < TABLE_SIZE) begin
			p = FREQ_W'(TUNE_PITCH[pos]);
		end
		return p;
	endfunction

	// Duration of a song position in ticks
	function automatic logic [TICK_W-1:0] tune_len(input logic [POS_W-1:0] pos);
		logic [TICK_W-1:0] l;
		l = PAST_END_LEN;
		if (32'(pos) < TABLE_SIZE) begin
			l = TUNE_LEN[pos];
		end
		return l;
	endfunction

	// Controller to datapath commands
	typedef struct packed {
		logic step;
		logic div_start;
		logic load_out;
	} mts_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_div;
		logic div_done;
	} mts_status_t;

	// Result item
	typedef struct packed {
		logic [HP_W-1:0]  half_period;
		logic             tone_on;
		logic [DAC_W-1:0] dac_value;
		logic             effect_playing;
		logic [POS_W-1:0] note_position;
	} mts_rsp_t;

endpackage
`default_nettype wire

// ----- sv/mts_ifs.sv -----
// Request and response channel interfaces of the melody tone sequencer.
`default_nettype none
interface mts_req_if;
	import mts_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [FREQ_W-1:0] effect_freq;
	logic [TICK_W-1:0] effect_ticks;

	modport source (output valid, output op, output effect_freq, output effect_ticks,
		input ready);
	modport sink (input valid, input op, input effect_freq, input effect_ticks,
		output ready);
	modport mon (input valid, input ready, input op, input effect_freq, input effect_ticks);
endinterface

interface mts_rsp_if;
	import mts_pkg::*;
	logic             valid;
	logic             ready;
	logic [HP_W-1:0]  half_period;
	logic             tone_on;
	logic [DAC_W-1:0] dac_value;
	logic             effect_playing;
	logic [POS_W-1:0] note_position;

	modport source (output valid, output half_period, output tone_on, output dac_value,
		output effect_playing, output note_position, input ready);
	modport sink (input valid, input half_period, input tone_on, input dac_value,
		input effect_playing, input note_position, output ready);
	modport mon (input valid, input ready, input half_period, input tone_on,
		input dac_value, input effect_playing, input note_position);
endinterface
`default_nettype wire

// ----- sv/mts_div.sv -----
// Bit-serial restoring divider: (CLOCK_HZ / 2) / pitch, saturated to the timer width.
`default_nettype none
module mts_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mts_pkg::FREQ_W-1:0] divisor,
	output logic                       done,
	output logic [mts_pkg::HP_W-1:0]   quotient
);
	import mts_pkg::*;

	logic [QUO_W-1:0]  num_q;
	logic [FREQ_W-1:0] rem_q;
	logic [FREQ_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [FREQ_W:0]   trial;
	logic [FREQ_W:0]   diff;
	logic              fits;
	logic [31:0]       quo_wide;

	// Bring down the next dividend bit and try the subtraction
	assign trial = {rem_q, num_q[QUO_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	// Control: count one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out the top, quotient bits shift in the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= QUO_W'(HALF_CLK);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[QUO_W-2:0], fits};
			rem_q <= fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
		end
	end

	// Saturate to the timer reload width
	assign quo_wide = 32'(num_q);
	assign quotient = (quo_wide > 32'(HP_MAX)) ? HP_MAX : quo_wide[HP_W-1:0];
	assign done     = done_q;

endmodule
`default_nettype wire

// ----- sv/mts_dp.sv -----
// Datapath: melody and effect state, tone state, DAC level register, result register.
`default_nettype none
module mts_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mts_pkg::mts_cmd_t          cmd,
	output mts_pkg::mts_status_t       status,
	input  logic [mts_pkg::OP_W-1:0]   op,
	input  logic [mts_pkg::FREQ_W-1:0] effect_freq,
	input  logic [mts_pkg::TICK_W-1:0] effect_ticks,
	input  logic                       cfg_wr_en,
	input  logic [mts_pkg::DAC_W-1:0]  cfg_wr_data,
	output mts_pkg::mts_rsp_t          rsp
);
	import mts_pkg::*;

	logic [DAC_W-1:0]  dac_level_q;
	logic [POS_W-1:0]  note_pos_q,  note_pos_n;
	logic [TICK_W-1:0] note_left_q, note_left_n;
	logic              eff_act_q,   eff_act_n;
	logic [TICK_W-1:0] eff_left_q,  eff_left_n;
	logic [HP_W-1:0]   reload_q;
	logic              running_q,   running_n;
	logic              phase_q,     phase_n;
	logic [DAC_W-1:0]  dac_q,       dac_n;
	mts_rsp_t          rsp_q;

	logic [FREQ_W-1:0] p_cur;
	logic [FREQ_W-1:0] pitch;
	logic [TICK_W-1:0] left_dec;
	logic [POS_W:0]    pos_inc;
	logic [POS_W-1:0]  pos_next;
	logic              set_pitch;
	logic              resume;
	logic              clr_dac;
	logic              div_done;
	logic [HP_W-1:0]   quotient;

	// Next song position with wraparound
	assign pos_inc  = {1'b0, note_pos_q} + 1'b1;
	assign pos_next = (pos_inc >= (POS_W+1)'(SONG_LENGTH)) ? '0 : pos_inc[POS_W-1:0];
	assign left_dec = (note_left_q != '0) ? note_left_q - 1'b1 : '0;
	assign p_cur    = tune_pitch(note_pos_q);

	// Work out the state after one transaction
	always_comb begin
		note_pos_n  = note_pos_q;
		note_left_n = note_left_q;
		eff_act_n   = eff_act_q;
		eff_left_n  = eff_left_q;
		running_n   = running_q;
		phase_n     = phase_q;
		dac_n       = dac_q;
		set_pitch   = 1'b0;
		pitch       = '0;
		resume      = 1'b0;
		clr_dac     = 1'b0;
		case (op)
			OP_TICK: begin
				if (eff_act_q && (eff_left_q != '0)) begin
					eff_left_n = eff_left_q - 1'b1;
				end else begin
					// End any effect, resume the note, then count the note down
					resume    = eff_act_q;
					eff_act_n = 1'b0;
					clr_dac   = resume && (p_cur == '0);
					if (left_dec == '0) begin
						note_pos_n  = pos_next;
						note_left_n = tune_len(pos_next);
						set_pitch   = 1'b1;
						pitch       = tune_pitch(pos_next);
					end else begin
						note_left_n = left_dec;
						set_pitch   = resume;
						pitch       = p_cur;
					end
				end
			end
			OP_EFFECT: begin
				eff_act_n  = 1'b1;
				eff_left_n = effect_ticks;
				set_pitch  = 1'b1;
				pitch      = effect_freq;
			end
			OP_HALF: begin
				if (running_q) begin
					phase_n = !phase_q;
					dac_n   = phase_q ? '0 : dac_level_q;
				end
			end
			default: begin
			end
		endcase
		// Silence stops the timer and drops the DAC; a pitch restarts it
		if (set_pitch) begin
			if (pitch == '0) begin
				running_n = 1'b0;
				dac_n     = '0;
			end else begin
				running_n = 1'b1;
			end
		end
		if (clr_dac) begin
			dac_n = '0;
		end
	end

	assign status.need_div = set_pitch && (pitch != '0);
	assign status.div_done = div_done;

	mts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (pitch),
		.done     (div_done),
		.quotient (quotient)
	);

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dac_level_q <= DAC_LEVEL_RST;
			note_pos_q  <= '0;
			note_left_q <= tune_len('0);
			eff_act_q   <= 1'b0;
			eff_left_q  <= '0;
			reload_q    <= RELOAD_RST;
			running_q   <= 1'b1;
			phase_q     <= 1'b0;
			dac_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				dac_level_q <= cfg_wr_data;
			end
			if (cmd.step) begin
				note_pos_q  <= note_pos_n;
				note_left_q <= note_left_n;
				eff_act_q   <= eff_act_n;
				eff_left_q  <= eff_left_n;
				running_q   <= running_n;
				phase_q     <= phase_n;
				dac_q       <= dac_n;
			end
			if (div_done) begin
				reload_q <= quotient;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.half_period    <= running_q ? reload_q : '0;
			rsp_q.tone_on        <= running_q;
			rsp_q.dac_value      <= dac_q;
			rsp_q.effect_playing <= eff_act_q;
			rsp_q.note_position  <= note_pos_q;
		end
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

// ----- sv/mts_ctrl.sv -----
// Controller: accepts a transaction, waits for the divider, hands the result out.
`default_nettype none
module mts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mts_pkg::mts_cmd_t    cmd,
	input  mts_pkg::mts_status_t status
);
	import mts_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_PUSH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Commands
	assign in_ready      = (state_q == S_IDLE);
	assign cmd.step      = (state_q == S_IDLE) && in_valid;
	assign cmd.div_start = cmd.step && status.need_div;
	assign cmd.load_out  = (state_q == S_PUSH) && (!out_valid_q || out_ready);
	assign out_valid     = out_valid_q;

	// State and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= status.need_div ? S_DIV : S_PUSH;
					end
				end
				S_DIV: begin
					if (status.div_done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Raise valid on a load, drop it once the response is taken
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/melody_tone_sequencer_core.sv -----
// Looping melody player with sound-effect override: top level.
// Each request transaction yields exactly one response carrying the tone timer
// reload, tone enable, DAC code, effect flag and note position. A transaction
// that ends with no new nonzero pitch goes from acceptance straight to the
// output register once that is free; one that loads a nonzero pitch (effect
// request, note change or effect end) first waits for the bit-serial divider,
// which forms CLOCK_HZ / (2 * pitch) one quotient bit per cycle over 24 bits.
// One transaction is worked on at a time; the next is accepted while the
// previous response still waits in the output register.
// dac_level may be written at any time the block is idle and takes effect at
// the next half-period event.
`default_nettype none
module melody_tone_sequencer_core (
	input  logic                      clk,
	input  logic                      arst_n,
	mts_req_if.sink                   req,
	mts_rsp_if.source                 rsp,
	input  logic                      cfg_wr_en,
	input  logic [mts_pkg::DAC_W-1:0] cfg_wr_data
);
	import mts_pkg::*;

	mts_cmd_t    cmd;
	mts_status_t status;
	mts_rsp_t    rsp_data;

	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.status    (status)
	);

	mts_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.op           (req.op),
		.effect_freq  (req.effect_freq),
		.effect_ticks (req.effect_ticks),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.rsp          (rsp_data)
	);

	// Drive the response payload
	assign rsp.half_period    = rsp_data.half_period;
	assign rsp.tone_on        = rsp_data.tone_on;
	assign rsp.dac_value      = rsp_data.dac_value;
	assign rsp.effect_playing = rsp_data.effect_playing;
	assign rsp.note_position  = rsp_data.note_position;

endmodule
`default_nettype wire

// ----- sv/mts_checker.sv -----
// Port-level checker for the melody tone sequencer, bound to the top level.
`default_nettype none
module mts_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [mts_pkg::HP_W-1:0]  half_period,
	input logic                      tone_on,
	input logic [mts_pkg::DAC_W-1:0] dac_value,
	input logic [mts_pkg::POS_W-1:0] note_position
);
	import mts_pkg::*;

	logic [1:0] pend_q;

	// Track transactions accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({req_valid && req_ready, rsp_valid && rsp_ready})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(half_period)
			&& $stable(note_position))
		else $error("response dropped or changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pend_q != 2'd0) && (pend_q != 2'd3))
		else $error("response without a matching request");

	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !tone_on |-> (half_period == '0) && (dac_value == '0))
		else $error("stopped tone reports a period or a DAC level");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(note_position) < SONG_LENGTH)
		else $error("note position past the song");

endmodule

bind melody_tone_sequencer_core mts_checker u_mts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.half_period   (rsp.half_period),
	.tone_on       (rsp.tone_on),
	.dac_value     (rsp.dac_value),
	.note_position (rsp.note_position)
);
`default_nettype wire

// ----- test/mts_tone_checker.sv -----
// Response checker for the melody tone sequencer: tracks the player state and compares responses.
module mts_tone_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	mts_req_if.mon                    req,
	mts_rsp_if.mon                    rsp,
	input  logic                      cfg_wr_en,
	input  logic [mts_pkg::DAC_W-1:0] cfg_wr_data,
	output int                        errors,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import mts_pkg::*;

	localparam int STORED_NOTES   = 39;
	localparam int FILLER_TICKS   = 20;
	localparam int LEVEL_AT_RESET = 128;
	localparam int PRINT_CAP      = 40;

	// Melody: pitch in hertz and length in ticks of each stored note
	int note_hz [STORED_NOTES] = '{
		659, 494, 523, 587, 523, 494, 440, 440, 523, 659, 587, 523,
		494, 523, 587, 659, 523, 440, 440, 0,
		587, 698, 880, 784, 698, 659, 523, 659, 587, 523,
		494, 494, 523, 587, 659, 523, 440, 440, 0
	};
	int note_ticks [STORED_NOTES] = '{
		20, 10, 10, 20, 10, 10, 20, 10, 10, 20, 10, 10,
		20, 10, 20, 20, 20, 20, 20, 20,
		20, 10, 20, 10, 10, 30, 10, 20, 10, 10,
		20, 10, 10, 20, 20, 20, 20, 20, 20
	};

	// Player state as the block should hold it
	int unsigned      song_pos;
	int unsigned      note_left;
	int unsigned      fx_left;
	bit               fx_on;
	bit               timer_on;
	bit               wave_hi;
	logic [HP_W-1:0]  reload;
	logic [DAC_W-1:0] dac_code;
	logic [DAC_W-1:0] dac_level;

	mts_rsp_t expected_tones [$];
	int       err_cnt   = 0;
	int       rsp_count = 0;
	int       depth     = 0;

	assign errors  = err_cnt;
	assign pending = depth;

	task automatic report(input string msg);
		err_cnt++;
		if (err_cnt <= PRINT_CAP) begin
			$display("mts_tone_checker: response %0d: %s", rsp_count, msg);
		end
	endtask

	function automatic int unsigned hz_at(input int unsigned pos);
		return (pos < STORED_NOTES) ? note_hz[pos] : 0;
	endfunction

	function automatic int unsigned ticks_at(input int unsigned pos);
		return (pos < STORED_NOTES) ? note_ticks[pos] : FILLER_TICKS;
	endfunction

	// Load the tone timer for a pitch; zero silences the output
	task automatic load_pitch(input int unsigned hz);
		longint unsigned q;
		if (hz == 0) begin
			timer_on = 1'b0;
			dac_code = '0;
		end else begin
			q = longint'(CLOCK_HZ) / (2 * longint'(hz));
			if (q > longint'(HP_MAX)) begin
				q = longint'(HP_MAX);
			end
			reload   = HP_W'(q);
			timer_on = 1'b1;
		end
	endtask

	task automatic reset_player();
		dac_level = DAC_W'(LEVEL_AT_RESET);
		fx_on     = 1'b0;
		fx_left   = 0;
		wave_hi   = 1'b0;
		dac_code  = '0;
		reload    = '0;
		timer_on  = 1'b0;
		song_pos  = 0;
		note_left = ticks_at(0);
		load_pitch(hz_at(0));
	endtask

	// Sequencer tick: an effect counts down first, then the note
	task automatic play_tick();
		bit held;
		held = 1'b0;
		if (fx_on) begin
			if (fx_left > 0) begin
				fx_left--;
				held = 1'b1;
			end else begin
				fx_on = 1'b0;
				load_pitch(hz_at(song_pos));
			end
		end
		if (!held) begin
			if (note_left > 0) begin
				note_left--;
			end
			if (note_left == 0) begin
				song_pos++;
				if (song_pos >= SONG_LENGTH) begin
					song_pos = 0;
				end
				note_left = ticks_at(song_pos);
				load_pitch(hz_at(song_pos));
			end
		end
	endtask

	task automatic play_request(input logic [OP_W-1:0] kind, input logic [FREQ_W-1:0] hz,
		input logic [TICK_W-1:0] count);
		case (kind)
			OP_TICK: begin
				play_tick();
			end
			OP_EFFECT: begin
				fx_on   = 1'b1;
				fx_left = count;
				load_pitch(hz);
			end
			OP_HALF: begin
				// toggle the square wave only while the timer runs
				if (timer_on) begin
					wave_hi  = !wave_hi;
					dac_code = wave_hi ? dac_level : '0;
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic mts_rsp_t tone_outputs();
		mts_rsp_t r;
		r.half_period    = timer_on ? reload : '0;
		r.tone_on        = timer_on;
		r.dac_value      = dac_code;
		r.effect_playing = fx_on;
		r.note_position  = POS_W'(song_pos);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mts_rsp_t want;
		if (!arst_n) begin
			reset_player();
			expected_tones.delete();
			depth <= 0;
		end else begin
			// compare the response transaction with the oldest prediction
			if (rsp.valid && rsp.ready) begin
				rsp_count++;
				if (expected_tones.size() == 0) begin
					report("response with no request outstanding");
				end else begin
					want = expected_tones.pop_front();
					if (rsp.half_period !== want.half_period)
						report($sformatf("half_period got %0d want %0d",
							rsp.half_period, want.half_period));
					if (rsp.tone_on !== want.tone_on)
						report($sformatf("tone_on got %0b want %0b", rsp.tone_on, want.tone_on));
					if (rsp.dac_value !== want.dac_value)
						report($sformatf("dac_value got %0d want %0d",
							rsp.dac_value, want.dac_value));
					if (rsp.effect_playing !== want.effect_playing)
						report($sformatf("effect_playing got %0b want %0b",
							rsp.effect_playing, want.effect_playing));
					if (rsp.note_position !== want.note_position)
						report($sformatf("note_position got %0d want %0d",
							rsp.note_position, want.note_position));
				end
			end
			if (cfg_wr_en) begin
				dac_level = cfg_wr_data;
			end
			// advance the player on each request transaction
			if (req.valid && req.ready) begin
				play_request(req.op, req.effect_freq, req.effect_ticks);
				expected_tones.push_back(tone_outputs());
			end
			depth <= expected_tones.size();
		end
	end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the melody tone sequencer: clock, reset, stimulus and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mts_pkg::*;

	localparam logic [OP_W-1:0] OP_NOP = 2'd3;
	localparam int PHASES       = 4;
	localparam int PHASE_ITEMS  = 500;
	localparam int DRAIN_EVERY  = 125;
	localparam int HOLD_AT_ITEM = 200;
	localparam int HOLD_CYCLES  = 300;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [DAC_W-1:0] cfg_wr_data;
	int               req_idle_pct;
	int               rsp_stall_pct;
	int               rsp_hold;
	int               errors;
	int               pending;

	// Idling per phase: none, sender only, receiver only, both lightly
	int               sender_idle [PHASES]  = '{0, 76, 0, 17};
	int               receiver_idle [PHASES] = '{0, 0, 76, 17};
	logic [DAC_W-1:0] levels [PHASES];

	mts_req_if req_ch ();
	mts_rsp_if rsp_ch ();

	melody_tone_sequencer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	mts_tone_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.errors      (errors),
		.pending     (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Response side: hold off for a counted stretch, otherwise stall at random
	always @(posedge clk) begin
		if (rsp_hold > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold--;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// Offer one request transaction after a random gap; return once accepted
	task automatic offer(input logic [OP_W-1:0] kind, input logic [FREQ_W-1:0] hz,
		input logic [TICK_W-1:0] count);
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.op           <= kind;
		req_ch.effect_freq  <= hz;
		req_ch.effect_ticks <= count;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Drop valid and wait until every response has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_level(input logic [DAC_W-1:0] level);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= level;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Mostly ticks and half periods, with short effects and a little noise
	task automatic random_item();
		int                r;
		logic [OP_W-1:0]   kind;
		logic [FREQ_W-1:0] hz;
		logic [TICK_W-1:0] count;
		r     = $urandom_range(99);
		hz    = FREQ_W'($urandom);
		count = TICK_W'($urandom);
		if (r < 66) begin
			kind = OP_TICK;
		end else if (r < 73) begin
			kind = OP_EFFECT;
			case ($urandom_range(9))
				0: hz = '0;
				1, 2: ;
				default: hz = FREQ_W'($urandom_range(2000, 100));
			endcase
			if ($urandom_range(79) != 0) begin
				count = TICK_W'($urandom_range(3));
			end
		end else if (r < 96) begin
			kind = OP_HALF;
		end else begin
			kind = OP_NOP;
		end
		offer(kind, hz, count);
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_wr_data         = '0;
		req_ch.valid        = 1'b0;
		req_ch.op           = OP_TICK;
		req_ch.effect_freq  = '0;
		req_ch.effect_ticks = '0;
		rsp_ch.ready        = 1'b0;
		rsp_hold            = 0;
		req_idle_pct        = 0;
		rsp_stall_pct       = 0;
		levels = '{10'h3FF, 10'h000, 10'h155, DAC_W'($urandom_range(1022, 1))};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Square wave at the reset level, then the unused operation
		offer(OP_HALF, '0, '0);
		offer(OP_HALF, '0, '0);
		offer(OP_HALF, '0, '0);
		offer(OP_NOP, '1, '1);
		// Silence keeps the phase; a half period while stopped changes nothing
		offer(OP_EFFECT, '0, '0);
		offer(OP_HALF, '0, '0);
		// Restart at the highest pitch and longest effect
		offer(OP_EFFECT, '1, '1);
		offer(OP_HALF, '0, '0);
		// Lowest pitch gives the largest half period; count it down to the end
		offer(OP_EFFECT, FREQ_W'(1), TICK_W'(2));
		offer(OP_TICK, '0, '0);
		offer(OP_TICK, '0, '0);
		offer(OP_TICK, '0, '0);
		// Effect with no ticks ends on the next tick, which also counts the note
		offer(OP_EFFECT, FREQ_W'(20000), '0);
		offer(OP_TICK, '0, '0);
		offer(OP_HALF, '0, '0);
		repeat (6) offer(OP_TICK, '0, '0);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_level(levels[ph]);
			req_idle_pct  = sender_idle[ph];
			rsp_stall_pct = receiver_idle[ph];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold the response side off so the request side backs up
				if (ph == 0 && i == HOLD_AT_ITEM) begin
					rsp_hold = HOLD_CYCLES;
				end
				if (i % DRAIN_EVERY == DRAIN_EVERY - 1) begin
					drain();
				end
				random_item();
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin
		#10_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
